@@ sv/favc_pkg.sv @@
`timescale 1ns / 1ps
package favc_pkg;

	// default configuration of the filter and heading units
	localparam int FAVC_FRAC_BITS = 24;
	localparam int FAVC_ANGLE_ITERATIONS = 16;

	// filter coefficients at 32 fractional bits
	localparam logic [63:0] KF_AT32 = 64'd4033242751;
	localparam logic [63:0] KI_AT32 = 64'd130862272;

	// datapath widths
	localparam int FW = 40;        // filter state word, q16.16 in 40 bits
	localparam int SW = 41;        // channel sums and differences
	localparam int CW = 45;        // heading vector
	localparam int AW = 26;        // heading angle, 2^-16 degree units
	localparam int MAG_W = 25;     // magnitude operands below the huge limit
	localparam int NW = 52;        // sum of squares, padded to whole digit pairs
	localparam int RTW = 26;       // square root
	localparam int RMW = 28;       // square root remainder
	localparam int DIV_W = 38;     // divider dividend and quotient
	localparam int DVS_W = 8;      // divider divisor

	localparam logic signed [AW-1:0] ANG_90 = 26'sd5898240;
	localparam logic [13:0] SPEED_MAX = 14'd10000;

	// atan(2^-i) in 2^-16 degree units
	localparam logic [21:0] ATAN_TAB [32] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
		22'd234379, 22'd117304, 22'd58666, 22'd29335,
		22'd14668, 22'd7334, 22'd3667, 22'd1833,
		22'd917, 22'd458, 22'd229, 22'd115,
		22'd57, 22'd29, 22'd14, 22'd7,
		22'd4, 22'd2, 22'd1, 22'd0,
		22'd0, 22'd0, 22'd0, 22'd0,
		22'd0, 22'd0, 22'd0, 22'd0
	};

	// register indexes
	localparam logic [2:0] REG_LEFT_OFFSET_A = 3'd0;
	localparam logic [2:0] REG_LEFT_OFFSET_B = 3'd1;
	localparam logic [2:0] REG_RIGHT_OFFSET_A = 3'd2;
	localparam logic [2:0] REG_RIGHT_OFFSET_B = 3'd3;
	localparam logic [2:0] REG_LINEAR_FULL_SCALE = 3'd4;
	localparam logic [2:0] REG_ANGULAR_FULL_SCALE = 3'd5;
	localparam logic [2:0] REG_DEAD_BAND_PERCENT = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILT,
		ST_FWAIT,
		ST_CINIT,
		ST_CORD,
		ST_SQX,
		ST_SQY,
		ST_SQRT,
		ST_DLIN,
		ST_DLWAIT,
		ST_DANG,
		ST_DAWAIT,
		ST_FIN
	} favc_state_t;

	// status of a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} favc_unit_sts_t;

	// round a 32-fraction-bit coefficient down to frac bits
	function automatic logic [31:0] favc_coef(input logic [63:0] at32, input int frac);
		logic [63:0] v;
		int fd;
		fd = 32 - frac;
		v = at32 + ((64'd1 << fd) >> 1);
		return 32'(v >> fd);
	endfunction

endpackage

@@ sv/force_admittance_velocity_command_unit.sv @@
`timescale 1ns / 1ps
// force admittance velocity command unit
//
// input stream: one beat per control tick. s_axis_tdata carries the left and
// right planar force readings (q16.16 newtons), s_axis_tuser the two reading
// flags; a side whose flag is low reuses its held filtered values.
// output stream: one beat per input beat with heading (tenths of a degree),
// linear speed and signed angular speed (hundredths of a percent).
// config: apb port, seven 32-bit registers at byte addresses 0..24, pready
// always high; write only while no tick is in flight.
//
// the four filter channels share a pair of bit-serial coefficient multipliers
// (one coefficient bit a cycle), then the heading unit takes one cordic step a
// cycle, the magnitude root one digit a cycle and the two speed divisions one
// quotient bit a cycle. one tick is worked on at a time; the next input beat is
// taken once the result sits in the output register.
// a stalled receiver holds the output beat; the unit may still take and work
// a new tick, then waits with its result until the output register is free.
// reset clears the filter history, sets the registers to their reset values
// and empties the output register.
module force_admittance_velocity_command_unit import favc_pkg::*; #(
	parameter int FILTER_FRAC_BITS = FAVC_FRAC_BITS,
	parameter int ANGLE_ITERATIONS = FAVC_ANGLE_ITERATIONS
) (
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// left_force_a, left_force_b, right_force_a, right_force_b (lsb first)
	input  logic [127:0] s_axis_tdata,
	// left_valid, right_valid (lsb first)
	input  logic [1:0]   s_axis_tuser,
	// output stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// direction_decideg, linear_speed_centipct, angular_speed_centipct, zero pad
	output logic [47:0]  m_axis_tdata,
	// config port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam logic [FILTER_FRAC_BITS-1:0] KI_COEF =
		FILTER_FRAC_BITS'(favc_coef(KI_AT32, FILTER_FRAC_BITS));
	localparam logic [FILTER_FRAC_BITS-1:0] KF_COEF =
		FILTER_FRAC_BITS'(favc_coef(KF_AT32, FILTER_FRAC_BITS));

	favc_state_t state_q, state_d;

	// config registers
	logic signed [31:0] off_la_q, off_lb_q, off_ra_q, off_rb_q;
	logic [7:0]         lin_fs_q, ang_fs_q;
	logic [6:0]         dead_band_q;
	logic               cfg_wr;
	logic [2:0]         cfg_idx;

	// filter history and channel inputs, order x left, y left, x right, y right
	logic signed [FW-1:0] prev_x_q [4];
	logic signed [FW-1:0] prev_y_q [4];
	logic signed [FW-1:0] cin_q [4];
	logic [1:0]           ch_q;

	// multipliers
	logic                 mul_start;
	logic signed [FW:0]   r_ki, r_kf;
	favc_unit_sts_t       ki_sts, kf_sts;
	logic signed [FW+2:0] ysum;
	logic signed [FW-1:0] ysat;

	// heading, magnitude and speed working registers
	logic signed [CW-1:0] cx_q, cy_q;
	logic signed [AW-1:0] ang_q;
	logic                 zero_q;
	logic [5:0]           cnt_q;
	logic [MAG_W-1:0]     ax_q, ay_q;
	logic                 huge_q;
	logic [FW-1:0]        dmag_q;
	logic                 dneg_q;
	logic [49:0]          sq_q;
	logic [49:0]          ay_sq;
	logic [NW-1:0]        n_q;
	logic [RMW-1:0]       rem_q;
	logic [RTW-1:0]       root_q;
	logic [13:0]          lin_spd_q;
	logic signed [14:0]   ang_spd_q;

	// output register
	logic                 m_valid_q;
	logic [11:0]          out_dir_q;
	logic [13:0]          out_lin_q;
	logic [14:0]          out_ang_q;

	// divider
	logic                 div_start;
	logic [DIV_W-1:0]     div_dividend;
	logic [DVS_W-1:0]     div_divisor;
	logic [DIV_W-1:0]     div_quot;
	favc_unit_sts_t       div_sts;

	logic                 in_beat;
	logic                 out_load;
	logic [13:0]          db_cp;

	// combinational datapath values
	logic signed [SW-1:0] sx, sy, dd;
	logic [SW-1:0]        absx, absy;
	logic signed [CW-1:0] sx_w, sy_w;
	logic signed [CW-1:0] dx, dy;
	logic [4:0]           sh;
	logic signed [AW-1:0] atan_s;
	logic [29:0]          rn;
	logic [RMW-1:0]       trial;
	logic [39:0]          lin_prod;
	logic [53:0]          ang_prod;
	logic signed [29:0]   a10;
	logic signed [13:0]   hdg;
	logic [11:0]          dir_w;
	logic [13:0]          ud;

	function automatic logic [13:0] speed_fix(input logic [DIV_W-1:0] q,
		input logic [13:0] db);
		logic [13:0] v;
		// dead band first, then clamp to full speed
		if (q < DIV_W'(db))
			v = '0;
		else if (q > DIV_W'(SPEED_MAX))
			v = SPEED_MAX;
		else
			v = q[13:0];
		return v;
	endfunction

	function automatic logic signed [39:0] in_chan(input logic [31:0] f,
		input logic signed [31:0] off, input logic negate);
		logic signed [32:0] t;
		// negated axis: off - f equals -(f - off)
		if (negate)
			t = $signed({off[31], off}) - $signed({f[31], f});
		else
			t = $signed({f[31], f}) - $signed({off[31], off});
		return {{7{t[32]}}, t};
	endfunction

	// ------------------------------------------------------------------
	// config port
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (cfg_idx)
			REG_LEFT_OFFSET_A:      prdata = off_la_q;
			REG_LEFT_OFFSET_B:      prdata = off_lb_q;
			REG_RIGHT_OFFSET_A:     prdata = off_ra_q;
			REG_RIGHT_OFFSET_B:     prdata = off_rb_q;
			REG_LINEAR_FULL_SCALE:  prdata = {24'd0, lin_fs_q};
			REG_ANGULAR_FULL_SCALE: prdata = {24'd0, ang_fs_q};
			REG_DEAD_BAND_PERCENT:  prdata = {25'd0, dead_band_q};
			default:                prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_la_q <= '0;
			off_lb_q <= '0;
			off_ra_q <= '0;
			off_rb_q <= '0;
			lin_fs_q <= 8'd60;
			ang_fs_q <= 8'd60;
			dead_band_q <= 7'd10;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_LEFT_OFFSET_A:      off_la_q <= pwdata;
				REG_LEFT_OFFSET_B:      off_lb_q <= pwdata;
				REG_RIGHT_OFFSET_A:     off_ra_q <= pwdata;
				REG_RIGHT_OFFSET_B:     off_rb_q <= pwdata;
				REG_LINEAR_FULL_SCALE:  lin_fs_q <= pwdata[7:0];
				REG_ANGULAR_FULL_SCALE: ang_fs_q <= pwdata[7:0];
				REG_DEAD_BAND_PERCENT:  dead_band_q <= pwdata[6:0];
				default:                ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_axis_tvalid) state_d = ST_FILT;
			ST_FILT:   state_d = ST_FWAIT;
			ST_FWAIT:  if (ki_sts.done) state_d = (ch_q == 2'd3) ? ST_CINIT : ST_FILT;
			ST_CINIT:  state_d = ST_CORD;
			ST_CORD:   if (cnt_q == 6'(ANGLE_ITERATIONS - 1)) state_d = ST_SQX;
			ST_SQX:    state_d = ST_SQY;
			ST_SQY:    state_d = ST_SQRT;
			ST_SQRT:   if (cnt_q == 6'(RTW - 1)) state_d = ST_DLIN;
			ST_DLIN:   state_d = ST_DLWAIT;
			ST_DLWAIT: if (div_sts.done) state_d = ST_DANG;
			ST_DANG:   state_d = ST_DAWAIT;
			ST_DAWAIT: if (div_sts.done) state_d = ST_FIN;
			ST_FIN:    if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_FILT: mul_start = 1'b1;
			ST_DLIN: div_start = 1'b1;
			ST_DANG: div_start = 1'b1;
			ST_FIN:  out_load = !m_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	assign in_beat = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// ------------------------------------------------------------------
	// low-pass filters: both products of a channel run side by side
	// ------------------------------------------------------------------
	favc_mulk #(.FRAC_BITS(FILTER_FRAC_BITS), .COEF(KI_COEF)) u_mul_ki (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(cin_q[ch_q]), .r(r_ki), .sts(ki_sts)
	);

	favc_mulk #(.FRAC_BITS(FILTER_FRAC_BITS), .COEF(KF_COEF)) u_mul_kf (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(prev_y_q[ch_q]), .r(r_kf), .sts(kf_sts)
	);

	// y = ki*x_prev + ki*x + kf*y_prev, saturated to 40 bits
	always_comb begin
		ysum = {{3{prev_x_q[ch_q][FW-1]}}, prev_x_q[ch_q]}
			+ {{2{r_ki[FW]}}, r_ki} + {{2{r_kf[FW]}}, r_kf};
		if (!ysum[FW+2] && ysum[FW+1:FW-1] != 3'b000)
			ysat = {1'b0, {(FW-1){1'b1}}};
		else if (ysum[FW+2] && ysum[FW+1:FW-1] != 3'b111)
			ysat = {1'b1, {(FW-1){1'b0}}};
		else
			ysat = ysum[FW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				prev_x_q[i] <= '0;
				prev_y_q[i] <= '0;
			end
			ch_q <= '0;
		end else begin
			if (in_beat)
				ch_q <= '0;
			else if (state_q == ST_FWAIT && ki_sts.done) begin
				// the scaled input never exceeds 40 bits
				prev_x_q[ch_q] <= r_ki[FW-1:0];
				prev_y_q[ch_q] <= ysat;
				ch_q <= ch_q + 1'b1;
			end
		end
	end

	// channel inputs, offsets removed; a missing side holds its filter output
	always_ff @(posedge clk) begin
		if (in_beat) begin
			cin_q[0] <= s_axis_tuser[0] ? in_chan(s_axis_tdata[63:32], off_lb_q, 1'b0)
				: prev_y_q[0];
			cin_q[1] <= s_axis_tuser[0] ? in_chan(s_axis_tdata[31:0], off_la_q, 1'b1)
				: prev_y_q[1];
			cin_q[2] <= s_axis_tuser[1] ? in_chan(s_axis_tdata[127:96], off_rb_q, 1'b0)
				: prev_y_q[2];
			cin_q[3] <= s_axis_tuser[1] ? in_chan(s_axis_tdata[95:64], off_ra_q, 1'b1)
				: prev_y_q[3];
		end
	end

	// ------------------------------------------------------------------
	// sums, heading cordic, magnitude root
	// ------------------------------------------------------------------
	always_comb begin
		sx = {prev_y_q[0][FW-1], prev_y_q[0]} + {prev_y_q[2][FW-1], prev_y_q[2]};
		sy = {prev_y_q[1][FW-1], prev_y_q[1]} + {prev_y_q[3][FW-1], prev_y_q[3]};
		dd = {prev_y_q[1][FW-1], prev_y_q[1]} - {prev_y_q[3][FW-1], prev_y_q[3]};
		absx = sx[SW-1] ? SW'(-sx) : SW'(sx);
		absy = sy[SW-1] ? SW'(-sy) : SW'(sy);
		sx_w = {{(CW-SW){sx[SW-1]}}, sx};
		sy_w = {{(CW-SW){sy[SW-1]}}, sy};
		sh = cnt_q[4:0];
		dx = cy_q >>> sh;
		dy = cx_q >>> sh;
		atan_s = $signed({{(AW-22){1'b0}}, ATAN_TAB[sh]});
		ay_sq = ay_q * ay_q;
		rn = {rem_q, n_q[NW-1:NW-2]};
		trial = {root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (state_q == ST_CINIT || state_q == ST_SQY)
			cnt_q <= '0;
		else if (state_q == ST_CORD || state_q == ST_SQRT)
			cnt_q <= cnt_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_CINIT: begin
				// heading is atan2(sx, sy): vector x is sy, vector y is sx
				zero_q <= (sx == '0) && (sy == '0);
				if (sy[SW-1]) begin
					if (!sx[SW-1]) begin
						cx_q <= sx_w;
						cy_q <= -sy_w;
						ang_q <= ANG_90;
					end else begin
						cx_q <= -sx_w;
						cy_q <= sy_w;
						ang_q <= -ANG_90;
					end
				end else begin
					cx_q <= sy_w;
					cy_q <= sx_w;
					ang_q <= '0;
				end
				ax_q <= absx[MAG_W-1:0];
				ay_q <= absy[MAG_W-1:0];
				huge_q <= (absx[SW-1:MAG_W] != '0) || (absy[SW-1:MAG_W] != '0);
				dneg_q <= dd[SW-1];
				dmag_q <= dd[SW-1] ? FW'(-dd) : FW'(dd);
			end
			ST_CORD: begin
				// a zero residual leaves the vector alone
				if (!cy_q[CW-1] && cy_q != '0) begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					ang_q <= ang_q + atan_s;
				end else if (cy_q[CW-1]) begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					ang_q <= ang_q - atan_s;
				end
			end
			ST_SQX: sq_q <= ax_q * ax_q;
			ST_SQY: begin
				n_q <= NW'(sq_q) + NW'(ay_sq);
				rem_q <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				// one root digit per cycle
				n_q <= n_q << 2;
				if (rn >= {2'b00, trial}) begin
					rem_q <= RMW'(rn - {2'b00, trial});
					root_q <= {root_q[RTW-2:0], 1'b1};
				end else begin
					rem_q <= rn[RMW-1:0];
					root_q <= {root_q[RTW-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// speed divisions, shared divider
	// ------------------------------------------------------------------
	always_comb begin
		lin_prod = {14'd0, root_q} * 40'd10000;
		ang_prod = {14'd0, dmag_q} * 54'd10000;
		db_cp = {7'd0, dead_band_q} * 14'd100;
		if (state_q == ST_DLIN) begin
			div_dividend = DIV_W'(lin_prod[39:16]);
			div_divisor = (lin_fs_q == '0) ? 8'd1 : lin_fs_q;
		end else begin
			div_dividend = ang_prod[53:16];
			div_divisor = (ang_fs_q == '0) ? 8'd1 : ang_fs_q;
		end
		ud = speed_fix(div_quot, db_cp);
	end

	favc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_dividend), .divisor(div_divisor),
		.quotient(div_quot), .sts(div_sts)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_DLWAIT && div_sts.done)
			// a huge force sum means full linear speed
			lin_spd_q <= huge_q ? speed_fix(DIV_W'(SPEED_MAX), db_cp) : ud;
		if (state_q == ST_DAWAIT && div_sts.done)
			ang_spd_q <= dneg_q ? -$signed({1'b0, ud}) : $signed({1'b0, ud});
	end

	// ------------------------------------------------------------------
	// heading to tenths of a degree, output register
	// ------------------------------------------------------------------
	always_comb begin
		a10 = ({{(30-AW){ang_q[AW-1]}}, ang_q} <<< 3)
			+ ({{(30-AW){ang_q[AW-1]}}, ang_q} <<< 1) + 30'sd32768;
		hdg = a10[29:16];
		if (zero_q)
			dir_w = '0;
		else if (hdg > 14'sd1800)
			dir_w = 12'd1800;
		else if (hdg < -14'sd1800)
			dir_w = 12'(-14'sd1800);
		else
			dir_w = hdg[11:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (out_load)
			m_valid_q <= 1'b1;
		else if (m_axis_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_dir_q <= dir_w;
			out_lin_q <= lin_spd_q;
			out_ang_q <= ang_spd_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = {7'd0, out_ang_q, out_lin_q, out_dir_q};

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_mul_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		ki_sts.done == kf_sts.done)
		else $error("filter multipliers out of step");

	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !ki_sts.busy && !div_sts.busy)
		else $error("input taken while a unit is busy");

	a_lin_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> out_lin_q <= SPEED_MAX)
		else $error("linear speed out of range");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_valid_q && state_q == ST_IDLE)
		else $error("result load did not complete");

endmodule

@@ sv/favc_mulk.sv @@
`timescale 1ns / 1ps
module favc_mulk import favc_pkg::*; #(
	parameter int FRAC_BITS = FAVC_FRAC_BITS,
	parameter logic [FRAC_BITS-1:0] COEF = '0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [FW-1:0] a,
	output logic signed [FW:0]   r,
	output favc_unit_sts_t       sts
);

	localparam int PW = FW + FRAC_BITS;
	localparam int CNTW = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;

	logic [PW-1:0]   p_q;
	logic [FW-1:0]   ua_q;
	logic            neg_q;
	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [FW:0]     sum;
	logic [FW:0]     mag;

	// one coefficient bit a cycle, lsb first
	always_comb begin
		sum = {1'b0, p_q[PW-1:FRAC_BITS]} + (p_q[0] ? {1'b0, ua_q} : '0);
		// round half away from zero on the magnitude
		mag = {1'b0, p_q[PW-1:FRAC_BITS]} + (FW+1)'(p_q[FRAC_BITS-1]);
	end

	assign r = neg_q ? -$signed(mag) : $signed(mag);
	assign sts.busy = busy_q;
	assign sts.done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(FRAC_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			p_q <= {{FW{1'b0}}, COEF};
			ua_q <= a[FW-1] ? FW'(-a) : FW'(a);
			neg_q <= a[FW-1];
		end else if (busy_q) begin
			p_q <= {sum, p_q[FRAC_BITS-1:1]};
		end
	end

endmodule

@@ sv/favc_div.sv @@
`timescale 1ns / 1ps
module favc_div import favc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic [DIV_W-1:0] quotient,
	output favc_unit_sts_t   sts
);

	localparam int CNTW = $clog2(DIV_W);

	logic [DIV_W-1:0] q_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dv_q;
	logic             busy_q;
	logic             done_q;
	logic [CNTW-1:0]  cnt_q;
	logic [DVS_W:0]   trial;
	logic             qbit;
	logic [DVS_W-1:0] rem_next;

	// restoring division, one quotient bit a cycle
	always_comb begin
		trial = {rem_q, q_q[DIV_W-1]};
		qbit = trial >= {1'b0, dv_q};
		rem_next = qbit ? DVS_W'(trial - {1'b0, dv_q}) : trial[DVS_W-1:0];
	end

	assign quotient = q_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			rem_q <= '0;
			dv_q <= divisor;
		end else if (busy_q) begin
			q_q <= {q_q[DIV_W-2:0], qbit};
			rem_q <= rem_next;
		end
	end

endmodule
